// ===== src/fpa_pkg.sv =====
// Shared types, constants and saturation helpers for the fixed-point arithmetic unit.
package fpa_pkg;

  // Number of fraction bits in the raw fixed-point format.
  localparam int unsigned FracBits = 8;

  // Width of the scaled, rounding-biased dividend and the number of divider steps.
  localparam int unsigned NumW     = 33 + FracBits;
  localparam int unsigned DivSteps = NumW;
  // Divisor is twice the operand magnitude; the partial remainder stays below it.
  localparam int unsigned DenW     = 33;
  localparam int unsigned RemW     = 33;

  // Queue between the front end and the execution pipeline.
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  // Rounding bias for the product: one half of the least significant result bit.
  localparam logic [63:0] ProdHalf = (64'd1 << FracBits) >> 1;

  localparam logic [31:0] MaxVal = 32'h7FFF_FFFF;
  localparam logic [31:0] MinVal = 32'h8000_0000;

  // Operation codes as they arrive on the input channel.
  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_MIN = 3'd4,
    OP_MAX = 3'd5
  } op_e;

  // Work class assigned by the front end.
  typedef enum logic [2:0] {
    CLS_ADD,
    CLS_SUB,
    CLS_MUL,
    CLS_DIV,
    CLS_DIV_ZERO,
    CLS_MIN,
    CLS_MAX,
    CLS_NONE
  } cls_e;

  // Input transaction.
  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } fpa_in_t;

  // Output transaction.
  typedef struct packed {
    logic signed [31:0] result_value;
    logic               a_less;
    logic               a_equal;
    logic               a_greater;
    logic               overflowed;
    logic               divide_by_zero;
  } fpa_out_t;

  // Classified item held in the queue.
  typedef struct packed {
    cls_e        cls;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
    logic [31:0] mag_a;
    logic [31:0] mag_b;
    logic        res_neg;
    logic        a_less;
    logic        a_equal;
    logic        a_greater;
  } fpa_item_t;

  // Side information that rides along the divider stages.
  typedef struct packed {
    cls_e        cls;
    logic        res_neg;
    logic [31:0] value;
    logic        ov;
    logic        dz;
    logic        a_less;
    logic        a_equal;
    logic        a_greater;
  } fpa_tag_t;

  // Saturated 32-bit value and its overflow flag.
  typedef struct packed {
    logic [31:0] value;
    logic        ov;
  } fpa_sat_t;

  // Applies a sign to an unsigned magnitude and saturates to 32 bits.
  function automatic fpa_sat_t sat_mag(logic [63:0] mag, logic neg);
    fpa_sat_t r;
    r.ov    = 1'b0;
    r.value = mag[31:0];
    if (neg) begin
      if (mag > 64'h0000_0000_8000_0000) begin
        r.ov    = 1'b1;
        r.value = MinVal;
      end else begin
        r.value = 32'd0 - mag[31:0];
      end
    end else if (mag > 64'h0000_0000_7FFF_FFFF) begin
      r.ov    = 1'b1;
      r.value = MaxVal;
    end
    return r;
  endfunction

  // Saturates a 33-bit two's complement sum to 32 bits.
  function automatic fpa_sat_t sat33(logic [32:0] v);
    fpa_sat_t r;
    r.ov    = v[32] != v[31];
    r.value = v[31:0];
    if (r.ov) begin
      r.value = v[32] ? MinVal : MaxVal;
    end
    return r;
  endfunction

endpackage

// ===== src/fpa_front.sv =====
// Front end: accepts input transactions, classifies them and forwards them to the queue.
module fpa_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  fpa_pkg::fpa_in_t   in_i,
  input  logic               full_i,
  output logic               push_o,
  output fpa_pkg::fpa_item_t item_o
);
  import fpa_pkg::*;

  logic      slot_valid_q;
  fpa_item_t slot_q;
  fpa_item_t cls_d;
  logic      accept;
  logic      a_neg;
  logic      b_neg;

  // The slot is held while the queue is full.
  assign in_stall_o = slot_valid_q && full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = slot_valid_q && !full_i;
  assign item_o     = slot_q;

  // Decode the operation, take magnitudes and compare the operands.
  always_comb begin
    a_neg           = in_i.operand_a[31];
    b_neg           = in_i.operand_b[31];
    cls_d.operand_a = in_i.operand_a;
    cls_d.operand_b = in_i.operand_b;
    cls_d.mag_a     = a_neg ? 32'd0 - in_i.operand_a : in_i.operand_a;
    cls_d.mag_b     = b_neg ? 32'd0 - in_i.operand_b : in_i.operand_b;
    cls_d.res_neg   = a_neg ^ b_neg;
    cls_d.a_less    = $signed(in_i.operand_a) < $signed(in_i.operand_b);
    cls_d.a_equal   = in_i.operand_a == in_i.operand_b;
    cls_d.a_greater = $signed(in_i.operand_a) > $signed(in_i.operand_b);
    unique case (in_i.operation)
      OP_ADD:  cls_d.cls = CLS_ADD;
      OP_SUB:  cls_d.cls = CLS_SUB;
      OP_MUL:  cls_d.cls = CLS_MUL;
      OP_DIV:  cls_d.cls = (in_i.operand_b == 32'd0) ? CLS_DIV_ZERO : CLS_DIV;
      OP_MIN:  cls_d.cls = CLS_MIN;
      OP_MAX:  cls_d.cls = CLS_MAX;
      default: cls_d.cls = CLS_NONE;
    endcase
  end

  // Slot valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= 1'b0;
    end else if (accept) begin
      slot_valid_q <= 1'b1;
    end else if (push_o) begin
      slot_valid_q <= 1'b0;
    end
  end

  // Slot payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      slot_q <= cls_d;
    end
  end

endmodule

// ===== src/fpa_queue.sv =====
// Short queue of classified items between the front end and the execution pipeline.
module fpa_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  fpa_pkg::fpa_item_t item_i,
  input  logic               pop_i,
  output fpa_pkg::fpa_item_t item_o,
  output logic               full_o,
  output logic               empty_o
);
  import fpa_pkg::*;

  fpa_item_t        entry_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q;
  logic [QPtrW-1:0] rd_ptr_q;
  logic [QCntW-1:0] count_q;

  assign full_o  = count_q == QCntW'(QueueDepth);
  assign empty_o = count_q == '0;
  assign item_o  = entry_q[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("queue written while full");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCntW'(QueueDepth))
    else $error("queue count beyond depth");
`endif

endmodule

// ===== src/fpa_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a side tag per stage.
module fpa_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [fpa_pkg::NumW-1:0]   num_i,
  input  logic [fpa_pkg::DenW-1:0]   den_i,
  input  fpa_pkg::fpa_tag_t          tag_i,
  output logic                       valid_o,
  output logic [fpa_pkg::NumW-1:0]   quot_o,
  output fpa_pkg::fpa_tag_t          tag_o
);
  import fpa_pkg::*;

  logic            valid_q [DivSteps];
  logic [RemW-1:0] rem_q   [DivSteps];
  logic [NumW-1:0] work_q  [DivSteps];
  logic [DenW-1:0] den_q   [DivSteps];
  fpa_tag_t        tag_q   [DivSteps];

  // Each stage shifts one dividend bit into the remainder and one quotient bit
  // into the low end of the work word.
  for (genvar g = 0; g < DivSteps; g++) begin : g_step
    logic            valid_in;
    logic [RemW-1:0] rem_in;
    logic [NumW-1:0] work_in;
    logic [DenW-1:0] den_in;
    fpa_tag_t        tag_in;
    logic [RemW:0]   trial;
    logic [RemW:0]   diff;
    logic            fits;

    if (g == 0) begin : g_first
      assign valid_in = valid_i;
      assign rem_in   = '0;
      assign work_in  = num_i;
      assign den_in   = den_i;
      assign tag_in   = tag_i;
    end else begin : g_next
      assign valid_in = valid_q[g-1];
      assign rem_in   = rem_q[g-1];
      assign work_in  = work_q[g-1];
      assign den_in   = den_q[g-1];
      assign tag_in   = tag_q[g-1];
    end

    assign trial = {rem_in, work_in[NumW-1]};
    assign diff  = trial - {1'b0, den_in};
    assign fits  = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[g] <= 1'b0;
      end else if (en_i) begin
        valid_q[g] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g]  <= fits ? diff[RemW-1:0] : trial[RemW-1:0];
        work_q[g] <= {work_in[NumW-2:0], fits};
        den_q[g]  <= den_in;
        tag_q[g]  <= tag_in;
      end
    end
  end

  assign valid_o = valid_q[DivSteps-1];
  assign quot_o  = work_q[DivSteps-1];
  assign tag_o   = tag_q[DivSteps-1];

`ifndef SYNTHESIS
  a_hold_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(valid_q[DivSteps-1]) && $stable(work_q[DivSteps-1]))
    else $error("divider stage moved while stalled");
`endif

endmodule

// ===== src/fpa_back.sv =====
// Execution pipeline: adder, multiplier, divider and result selection with an output register.
module fpa_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fpa_pkg::fpa_item_t item_i,
  input  logic               empty_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output fpa_pkg::fpa_out_t  out_o
);
  import fpa_pkg::*;

  logic            en;
  // Issue stage.
  logic            valid_a_q;
  fpa_item_t       item_a_q;
  // Operand stage.
  logic            valid_b_q;
  fpa_tag_t        tag_b_q;
  logic [63:0]     prod_b_q;
  logic [NumW-1:0] num_b_q;
  logic [DenW-1:0] den_b_q;
  fpa_tag_t        tag_b_d;
  fpa_sat_t        sum_sat;
  fpa_sat_t        dif_sat;
  // Divider entry and exit.
  fpa_tag_t        tag_div_in;
  fpa_sat_t        prod_sat;
  logic            div_valid;
  logic [NumW-1:0] div_quot;
  fpa_tag_t        div_tag;
  fpa_sat_t        quot_sat;
  // Output register.
  logic            out_valid_q;
  fpa_out_t        out_q;
  fpa_out_t        out_d;

  // The whole pipeline advances unless a finished result is held back.
  assign en          = !out_valid_q || !out_stall_i;
  assign pop_o       = en && !empty_i;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // Issue register loaded from the queue head.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
    end else if (en) begin
      valid_a_q <= !empty_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      item_a_q <= item_i;
    end
  end

  // Simple results: sum, difference, minimum, maximum and divide by zero.
  always_comb begin
    sum_sat = sat33({item_a_q.operand_a[31], item_a_q.operand_a}
                  + {item_a_q.operand_b[31], item_a_q.operand_b});
    dif_sat = sat33({item_a_q.operand_a[31], item_a_q.operand_a}
                  - {item_a_q.operand_b[31], item_a_q.operand_b});
    tag_b_d.cls       = item_a_q.cls;
    tag_b_d.res_neg   = item_a_q.res_neg;
    tag_b_d.a_less    = item_a_q.a_less;
    tag_b_d.a_equal   = item_a_q.a_equal;
    tag_b_d.a_greater = item_a_q.a_greater;
    tag_b_d.value     = '0;
    tag_b_d.ov        = 1'b0;
    tag_b_d.dz        = 1'b0;
    unique case (item_a_q.cls)
      CLS_ADD: begin
        tag_b_d.value = sum_sat.value;
        tag_b_d.ov    = sum_sat.ov;
      end
      CLS_SUB: begin
        tag_b_d.value = dif_sat.value;
        tag_b_d.ov    = dif_sat.ov;
      end
      CLS_MIN: begin
        tag_b_d.value = item_a_q.a_less ? item_a_q.operand_a : item_a_q.operand_b;
      end
      CLS_MAX: begin
        tag_b_d.value = item_a_q.a_greater ? item_a_q.operand_a : item_a_q.operand_b;
      end
      CLS_DIV_ZERO: begin
        tag_b_d.dz = 1'b1;
        if (item_a_q.operand_a == 32'd0) begin
          tag_b_d.value = '0;
        end else begin
          tag_b_d.value = item_a_q.operand_a[31] ? MinVal : MaxVal;
        end
      end
      CLS_MUL, CLS_DIV, CLS_NONE: begin
        tag_b_d.value = '0;
      end
      default: begin
        tag_b_d.value = '0;
      end
    endcase
  end

  // Operand stage: magnitude product and the biased, scaled dividend.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_b_q <= 1'b0;
    end else if (en) begin
      valid_b_q <= valid_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tag_b_q  <= tag_b_d;
      prod_b_q <= 64'(item_a_q.mag_a) * 64'(item_a_q.mag_b);
      num_b_q  <= (NumW'(item_a_q.mag_a) << (FracBits + 1)) + NumW'(item_a_q.mag_b);
      den_b_q  <= {item_a_q.mag_b, 1'b0};
    end
  end

  // Round the product half away from zero and saturate before it rides the divider.
  always_comb begin
    prod_sat   = sat_mag((prod_b_q + ProdHalf) >> FracBits, tag_b_q.res_neg);
    tag_div_in = tag_b_q;
    if (tag_b_q.cls == CLS_MUL) begin
      tag_div_in.value = prod_sat.value;
      tag_div_in.ov    = prod_sat.ov;
    end
  end

  fpa_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (valid_b_q),
    .num_i   (num_b_q),
    .den_i   (den_b_q),
    .tag_i   (tag_div_in),
    .valid_o (div_valid),
    .quot_o  (div_quot),
    .tag_o   (div_tag)
  );

  // Final selection: the quotient for a divide, the carried value otherwise.
  always_comb begin
    quot_sat             = sat_mag(64'(div_quot), div_tag.res_neg);
    out_d.a_less         = div_tag.a_less;
    out_d.a_equal        = div_tag.a_equal;
    out_d.a_greater      = div_tag.a_greater;
    out_d.divide_by_zero = div_tag.dz;
    if (div_tag.cls == CLS_DIV) begin
      out_d.result_value = quot_sat.value;
      out_d.overflowed   = quot_sat.ov;
    end else begin
      out_d.result_value = div_tag.value;
      out_d.overflowed   = div_tag.ov;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

endmodule

// ===== src/fixed_point_arith_unit.sv =====
// Top level of the signed 32-bit fixed-point arithmetic unit.
//
// Signed Q-format arithmetic on raw 32-bit operands with fpa_pkg::FracBits
// fraction bits: add, subtract, multiply, divide, minimum and maximum, plus
// less, equal and greater flags for every transaction. Products and quotients
// round half away from zero; results beyond 32 bits saturate and set
// overflowed. A divide by zero returns zero for a zero dividend and otherwise
// the limit with the dividend's sign, and sets divide_by_zero. The unit takes
// one transaction per cycle unless in_stall_o is raised and returns results in
// order. A result passes the front-end slot, the queue, two operand stages, one
// stage per quotient bit of the pipelined divider (NumW = 33 + FracBits stages,
// which every operation passes through to keep order) and the output register.
// A four-entry queue decouples the input side from output stalls.
module fixed_point_arith_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  fpa_pkg::fpa_in_t  in_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output fpa_pkg::fpa_out_t out_o
);
  import fpa_pkg::*;

  fpa_item_t push_item;
  fpa_item_t head_item;
  logic      push;
  logic      pop;
  logic      full;
  logic      empty;

  // Front end: accept and classify.
  fpa_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .full_i     (full),
    .push_o     (push),
    .item_o     (push_item)
  );

  // Queue between the two halves.
  fpa_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .item_o  (head_item),
    .full_o  (full),
    .empty_o (empty)
  );

  // Execution pipeline and output register.
  fpa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (head_item),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

endmodule
